>>> rtl/exfat_dir_entry_parser_defines.svh
// assertion macros used by the checker module exfat_chk
`ifndef EXFAT_DIR_ENTRY_PARSER_DEFINES_SVH
`define EXFAT_DIR_ENTRY_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define EXFAT_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("exfat check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define EXFAT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("exfat check failed");

`endif

>>> rtl/exfat_pkg.sv
package exfat_pkg;

   // entry geometry
   localparam int ENTRY_SIZE     = 32;
   localparam int POS_W          = 5;
   localparam int NAME_OFFSET    = 2;
   localparam int MAX_NAME_BYTES = 30;
   localparam int IDX_W          = 5;

   typedef logic [7:0] byte_type;

   // entry type codes
   localparam byte_type TYPE_STREAM = 8'hC0;
   localparam byte_type TYPE_NAME   = 8'hC1;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic save_stream;
      logic load_name;
      logic shift;
      logic emit_char;
      logic emit_empty;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pos_last;
      logic entry_end;
      logic type_stream;
      logic type_name;
      logic mask_zero;
      logic head_set;
      logic tail_zero;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/exfat_req_if.sv
interface exfat_req_if import exfat_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     block_start;

   modport source (output valid, output data_byte, output block_start, input ready);
   modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

>>> rtl/exfat_rsp_if.sv
interface exfat_rsp_if import exfat_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [31:0]      first_cluster;
   byte_type         chain_flags;
   logic [63:0]      data_length;
   byte_type         name_char;
   logic [IDX_W-1:0] char_index;
   logic             char_valid;
   logic             last;

   modport source (output valid, output first_cluster, output chain_flags,
                   output data_length, output name_char, output char_index,
                   output char_valid, output last, input ready);
   modport sink (input valid, input first_cluster, input chain_flags,
                 input data_length, input name_char, input char_index,
                 input char_valid, input last, output ready);
endinterface

>>> rtl/exfat_ctrl.sv
module exfat_ctrl import exfat_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type state_ff, state_in;
   logic      entry_done;

   // byte intake, entry completion waits while a name run drains
   always_comb begin
      req_ready      = (state_ff == ST_IDLE) || !status.pos_last;
      cmd            = '0;
      cmd.take_byte  = req_valid && req_ready;
      entry_done     = cmd.take_byte && status.entry_end;
      state_in       = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.save_stream = entry_done && status.type_stream;
            cmd.load_name   = entry_done && status.type_name;
            if (cmd.load_name) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // name bytes go one per cycle if out_free; zeros skip
            if (status.mask_zero) begin
               if (status.out_free) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (status.head_set) begin
               if (status.out_free) begin
                  cmd.emit_char = 1'b1;
                  cmd.shift     = 1'b1;
                  if (status.tail_zero) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.shift = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/exfat_dpath.sv
module exfat_dpath import exfat_pkg::*; #(
   parameter int NAME_BYTES = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_status_type    status,
   input  byte_type         req_data_byte,
   input  logic             req_block_start,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_first_cluster,
   output byte_type         rsp_chain_flags,
   output logic [63:0]      rsp_data_length,
   output byte_type         rsp_name_char,
   output logic [IDX_W-1:0] rsp_char_index,
   output logic             rsp_char_valid,
   output logic             rsp_last
);

   logic [POS_W-1:0]      pos_ff, pos_in, pos_eff;
   byte_type              entry_ff [ENTRY_SIZE];
   byte_type              name_view [NAME_BYTES];
   byte_type              drain_ff [NAME_BYTES];
   byte_type              drain_in [NAME_BYTES];
   logic [NAME_BYTES-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [31:0]           cluster_ff, cluster_in;
   byte_type              flags_ff, flags_in;
   logic [63:0]           length_ff, length_in;
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_cluster_ff, out_cluster_in;
   byte_type              out_flags_ff, out_flags_in;
   logic [63:0]           out_length_ff, out_length_in;
   byte_type              out_char_ff, out_char_in;
   logic [IDX_W-1:0]      out_idx_ff, out_idx_in;
   logic                  out_cvalid_ff, out_cvalid_in;
   logic                  out_last_ff, out_last_in;

   // entry alignment, block start restarts at byte zero
   assign pos_eff = req_block_start ? '0 : pos_ff;
   assign pos_in  = cmd.take_byte ? pos_eff + POS_W'(1) : pos_ff;

   // name bytes as seen when the final byte of the entry arrives
   always_comb begin
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (i + NAME_OFFSET == ENTRY_SIZE - 1) begin
            name_view[i] = req_data_byte;
         end else begin
            name_view[i] = entry_ff[POS_W'(i + NAME_OFFSET)];
         end
      end
   end

   // status toward the controller
   always_comb begin
      status.pos_last    = (pos_ff == POS_W'(ENTRY_SIZE - 1));
      status.entry_end   = (pos_eff == POS_W'(ENTRY_SIZE - 1));
      status.type_stream = (entry_ff[0] == TYPE_STREAM);
      status.type_name   = (entry_ff[0] == TYPE_NAME);
      status.mask_zero   = (mask_ff == '0);
      status.head_set    = mask_ff[0];
      status.tail_zero   = ((mask_ff >> 1) == '0);
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   // stream extension fields, little endian, last byte straight from input
   always_comb begin
      cluster_in = cluster_ff;
      flags_in   = flags_ff;
      length_in  = length_ff;
      if (cmd.save_stream) begin
         flags_in   = entry_ff[1];
         cluster_in = {entry_ff[23], entry_ff[22], entry_ff[21], entry_ff[20]};
         length_in  = {req_data_byte, entry_ff[30], entry_ff[29], entry_ff[28],
                       entry_ff[27], entry_ff[26], entry_ff[25], entry_ff[24]};
      end
   end

   // drain buffer: load a name entry, then shift one byte a step
   always_comb begin
      mask_in = mask_ff;
      idx_in  = idx_ff;
      for (int i = 0; i < NAME_BYTES; i++) begin
         drain_in[i] = drain_ff[i];
      end
      if (cmd.load_name) begin
         idx_in = '0;
         for (int i = 0; i < NAME_BYTES; i++) begin
            drain_in[i] = name_view[i];
            mask_in[i]  = (name_view[i] != '0);
         end
      end else if (cmd.shift) begin
         mask_in = mask_ff >> 1;
         for (int i = 0; i < NAME_BYTES - 1; i++) begin
            drain_in[i] = drain_ff[i + 1];
         end
         drain_in[NAME_BYTES - 1] = '0;
      end
      if (cmd.emit_char) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // output register
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_cluster_in = out_cluster_ff;
      out_flags_in   = out_flags_ff;
      out_length_in  = out_length_ff;
      out_char_in    = out_char_ff;
      out_idx_in     = out_idx_ff;
      out_cvalid_in  = out_cvalid_ff;
      out_last_in    = out_last_ff;
      if (cmd.emit_char || cmd.emit_empty) begin
         out_valid_in   = 1'b1;
         out_cluster_in = cluster_ff;
         out_flags_in   = flags_ff;
         out_length_in  = length_ff;
         out_char_in    = cmd.emit_char ? drain_ff[0] : '0;
         out_idx_in     = cmd.emit_char ? idx_ff : '0;
         out_cvalid_in  = cmd.emit_char;
         out_last_in    = cmd.emit_char ? status.tail_zero : 1'b1;
      end
   end

   // entry store, written at the alignment position
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         entry_ff[pos_eff] <= req_data_byte;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      drain_ff       <= drain_in;
      idx_ff         <= idx_in;
      out_cluster_ff <= out_cluster_in;
      out_flags_ff   <= out_flags_in;
      out_length_ff  <= out_length_in;
      out_char_ff    <= out_char_in;
      out_idx_ff     <= out_idx_in;
      out_cvalid_ff  <= out_cvalid_in;
      out_last_ff    <= out_last_in;
   end

   // control and saved state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         mask_ff      <= '0;
         cluster_ff   <= '0;
         flags_ff     <= '0;
         length_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         mask_ff      <= mask_in;
         cluster_ff   <= cluster_in;
         flags_ff     <= flags_in;
         length_ff    <= length_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_first_cluster = out_cluster_ff;
   assign rsp_chain_flags   = out_flags_ff;
   assign rsp_data_length   = out_length_ff;
   assign rsp_name_char     = out_char_ff;
   assign rsp_char_index    = out_idx_ff;
   assign rsp_char_valid    = out_cvalid_ff;
   assign rsp_last          = out_last_ff;

endmodule

>>> rtl/exfat_dir_entry_parser.sv
// channel   dir   word contents
// req_ch    in    data_byte, block_start
// rsp_ch    out   first_cluster, chain_flags, data_length, name_char,
//                 char_index, char_valid, last
//
// one byte is taken per cycle; results leave through a one-deep output register
// a name run walks the name bytes one per cycle unless rsp_ch stalls
// the final byte of an entry is held off while the previous name run drains
// a stalled rsp_ch only holds the drain; bytes inside an entry keep flowing
// reset is synchronous, no clearing pass
module exfat_dir_entry_parser import exfat_pkg::*; #(
   parameter int NAME_BYTES = 30
) (
   input logic        clock,
   input logic        reset,
   exfat_req_if.sink  req_ch,
   exfat_rsp_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   exfat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // entry store, saved fields, name drain and output register
   exfat_dpath #(
      .NAME_BYTES (NAME_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data_byte     (req_ch.data_byte),
      .req_block_start   (req_ch.block_start),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_first_cluster (rsp_ch.first_cluster),
      .rsp_chain_flags   (rsp_ch.chain_flags),
      .rsp_data_length   (rsp_ch.data_length),
      .rsp_name_char     (rsp_ch.name_char),
      .rsp_char_index    (rsp_ch.char_index),
      .rsp_char_valid    (rsp_ch.char_valid),
      .rsp_last          (rsp_ch.last)
   );

endmodule

>>> rtl/exfat_chk.sv
`include "exfat_dir_entry_parser_defines.svh"

module exfat_chk import exfat_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input byte_type         rsp_name_char,
   input logic [IDX_W-1:0] rsp_char_index,
   input logic             rsp_char_valid,
   input logic             rsp_last
);

   // a stalled word holds
   `EXFAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_name_char) && $stable(rsp_char_index) && $stable(rsp_last))

   // empty name word is a lone zero word marked last
   `EXFAT_ASSERT_SAME(a_empty_word, rsp_valid && !rsp_char_valid, rsp_last && rsp_char_index == '0 && rsp_name_char == '0)

   // a character word never carries a zero byte
   `EXFAT_ASSERT_SAME(a_char_nonzero, rsp_valid && rsp_char_valid, rsp_name_char != '0)

   // back-to-back words within one run count up by one
   `EXFAT_ASSERT_NEXT(a_index_step, rsp_valid && rsp_ready && !rsp_last, !rsp_valid || rsp_char_index == $past(rsp_char_index) + IDX_W'(1))

   // index stays within the name field
   `EXFAT_ASSERT_SAME(a_index_range, rsp_valid, rsp_char_index < IDX_W'(MAX_NAME_BYTES))

endmodule

bind exfat_dir_entry_parser exfat_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_name_char  (rsp_ch.name_char),
   .rsp_char_index (rsp_ch.char_index),
   .rsp_char_valid (rsp_ch.char_valid),
   .rsp_last       (rsp_ch.last)
);

>>> tb/exfat_dir_entry_checker.sv
`timescale 1ns / 1ps

module exfat_dir_entry_checker import exfat_pkg::*; #(
   parameter int NAME_BYTES = 30
) (
   input  logic clock,
   input  logic reset,
   exfat_req_if req_mon,
   exfat_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending
);

   // one result word as seen on the rsp channel
   typedef struct packed {
      logic [31:0]      first_cluster;
      byte_type         chain_flags;
      logic [63:0]      data_length;
      byte_type         name_char;
      logic [IDX_W-1:0] char_index;
      logic             char_valid;
      logic             last;
   } name_word_type;

   byte_type         entry_mem [ENTRY_SIZE];
   logic [POS_W-1:0] fill_pos;
   logic [31:0]      saved_cluster;
   byte_type         saved_flags;
   logic [63:0]      saved_length;
   name_word_type    char_q [$];

   function automatic name_word_type make_word(input byte_type ch, input int idx,
                                               input logic ok, input logic fin);
      name_word_type w;
      w.first_cluster = saved_cluster;
      w.chain_flags   = saved_flags;
      w.data_length   = saved_length;
      w.name_char     = ch;
      w.char_index    = IDX_W'(idx);
      w.char_valid    = ok;
      w.last          = fin;
      return w;
   endfunction

   // store one directory byte and predict the words of a completed entry
   task automatic absorb_byte(input byte_type d, input logic bs);
      logic [POS_W-1:0] pos;
      int               found;
      byte_type         c;
      name_word_type    w;
      if (bs) fill_pos = '0;
      pos = fill_pos;
      entry_mem[pos] = d;
      fill_pos = pos + POS_W'(1);
      if (pos == POS_W'(ENTRY_SIZE - 1)) begin
         if (entry_mem[0] == TYPE_STREAM) begin
            // little-endian fields of the stream extension
            saved_flags = entry_mem[1];
            for (int k = 0; k < 4; k++) saved_cluster[8*k +: 8] = entry_mem[20 + k];
            for (int k = 0; k < 8; k++) saved_length[8*k +: 8] = entry_mem[24 + k];
         end else if (entry_mem[0] == TYPE_NAME) begin
            // one word per non-zero name byte
            found = 0;
            for (int i = 0; i < NAME_BYTES; i++) begin
               c = entry_mem[(NAME_OFFSET + i) % ENTRY_SIZE];
               if (c != 8'h00) begin
                  char_q.push_back(make_word(c, found, 1'b1, 1'b0));
                  found++;
               end
            end
            if (found == 0) begin
               char_q.push_back(make_word(8'h00, 0, 1'b0, 1'b1));
            end else begin
               w = char_q.pop_back();
               w.last = 1'b1;
               char_q.push_back(w);
            end
         end
      end
   endtask

   // compare one accepted result word against the oldest prediction
   task automatic check_word();
      name_word_type got;
      name_word_type want;
      got.first_cluster = rsp_mon.first_cluster;
      got.chain_flags   = rsp_mon.chain_flags;
      got.data_length   = rsp_mon.data_length;
      got.name_char     = rsp_mon.name_char;
      got.char_index    = rsp_mon.char_index;
      got.char_valid    = rsp_mon.char_valid;
      got.last          = rsp_mon.last;
      if (char_q.size() == 0) begin
         if (fail_count < 10)
            $display("%0t: unexpected word ch=%h idx=%0d v=%b last=%b",
                     $realtime, got.name_char, got.char_index, got.char_valid, got.last);
         fail_count++;
      end else begin
         want = char_q.pop_front();
         if (got !== want) begin
            if (fail_count < 10) begin
               $display("%0t: word mismatch", $realtime);
               $display("  want cl=%h fl=%h len=%h ch=%h idx=%0d v=%b last=%b",
                        want.first_cluster, want.chain_flags, want.data_length,
                        want.name_char, want.char_index, want.char_valid, want.last);
               $display("  got  cl=%h fl=%h len=%h ch=%h idx=%0d v=%b last=%b",
                        got.first_cluster, got.chain_flags, got.data_length,
                        got.name_char, got.char_index, got.char_valid, got.last);
            end
            fail_count++;
         end
      end
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         fail_count    = 0;
         fill_pos      = '0;
         saved_cluster = '0;
         saved_flags   = '0;
         saved_length  = '0;
         for (int k = 0; k < ENTRY_SIZE; k++) entry_mem[k] = 8'h00;
         char_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            absorb_byte(req_mon.data_byte, req_mon.block_start);
         if (rsp_mon.valid && rsp_mon.ready)
            check_word();
      end
      pending = char_q.size();
   end

endmodule

>>> tb/tb_exfat_dir_entry_parser.sv
`timescale 1ns / 1ps

module tb_exfat_dir_entry_parser;
   import exfat_pkg::*;

   localparam int       NAME_LEN     = 30;
   localparam int       ITEM_TARGET  = 470;
   localparam int       CYCLE_LIMIT  = 200000;
   localparam int       DRAIN_CYCLES = 40;
   localparam int       HOLD_CYCLES  = 400;
   localparam byte_type TYPE_FILE    = 8'h85;

   logic     clock;
   logic     reset;
   int       cycle_count = 0;
   int       fail_count;
   int       pending;
   int       bytes_sent;
   logic     hold_rsp;
   logic     burst_mode;
   byte_type entry_buf [ENTRY_SIZE];

   exfat_req_if req_ch ();
   exfat_rsp_if rsp_ch ();

   exfat_dir_entry_parser #(.NAME_BYTES(NAME_LEN)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   exfat_dir_entry_checker #(.NAME_BYTES(NAME_LEN)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_exfat_dir_entry_parser NOT OK");
         $finish;
      end
   end

   // idle gap before a byte: mostly none, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one byte and hold it until accepted; starts and ends at a falling edge
   task automatic send_byte(input byte_type d, input logic bs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= d;
      req_ch.block_start <= bs;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_entry(input logic mark);
      for (int k = 0; k < ENTRY_SIZE; k++)
         send_byte(entry_buf[k], (k == 0) ? mark : 1'b0);
   endtask

   task automatic load_stream(input byte_type flags, input logic [31:0] cluster,
                              input logic [63:0] length);
      for (int k = 0; k < ENTRY_SIZE; k++) entry_buf[k] = byte_type'($urandom_range(0, 255));
      entry_buf[0] = TYPE_STREAM;
      entry_buf[1] = flags;
      for (int k = 0; k < 4; k++) entry_buf[20 + k] = cluster[8*k +: 8];
      for (int k = 0; k < 8; k++) entry_buf[24 + k] = length[8*k +: 8];
   endtask

   // name entry with the given share of zero name bytes, in percent
   task automatic load_name(input int zero_pct);
      entry_buf[0] = TYPE_NAME;
      entry_buf[1] = byte_type'($urandom_range(0, 255));
      for (int k = NAME_OFFSET; k < ENTRY_SIZE; k++)
         entry_buf[k] = ($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                           : byte_type'($urandom_range(1, 255));
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int   r;
      logic held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               rsp_ch.ready <= 1'b1;
               repeat (30) @(negedge clock);
            end else if (r < 72) begin
               rsp_ch.ready <= 1'b1;
            end else if (r < 97) begin
               rsp_ch.ready <= 1'b0;
               repeat ($urandom_range(0, 2)) @(negedge clock);
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat ($urandom_range(8, 40)) @(negedge clock);
            end
         end
      end
   end

   // byte stimulus and verdict
   initial begin : stimulus
      int   r;
      int   n;
      logic mark;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.block_start <= 1'b0;
      hold_rsp   = 1'b0;
      burst_mode = 1'b0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // name before any stream entry, aligned from reset without a marker
      load_name(50);
      send_entry(1'b0);
      // stream entry with every saved field at its maximum
      load_stream(8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_entry(1'b1);
      // longest run: every name byte non-zero
      burst_mode = 1'b1;
      load_name(0);
      send_entry(1'b1);
      burst_mode = 1'b0;
      // empty name
      load_name(100);
      send_entry(1'b1);
      // other entry type is ignored
      entry_buf[0] = TYPE_FILE;
      send_entry(1'b1);
      // distinct byte lanes check the little-endian layout
      load_stream(8'h03, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
      send_entry(1'b1);
      // partial entry cut short by a new block
      load_name(0);
      for (int k = 0; k < 10; k++) send_byte(entry_buf[k], k == 0);
      // single characters at the first and last name offsets
      load_name(100);
      entry_buf[NAME_OFFSET]    = 8'h01;
      entry_buf[ENTRY_SIZE - 1] = 8'h80;
      send_entry(1'b1);
      // stream entry with all saved fields zero
      load_stream(8'h00, 32'h0, 64'h0);
      send_entry(1'b1);
      load_name(70);
      send_entry(1'b1);

      // random part, with one long hold-off on the result side
      hold_rsp = 1'b1;
      while (bytes_sent < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         mark = ($urandom_range(0, 7) != 0);
         r = $urandom_range(0, 99);
         if (r < 42) begin
            load_name(($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 90));
            send_entry(mark);
         end else if (r < 76) begin
            load_stream(byte_type'($urandom_range(0, 255)), $urandom, {$urandom, $urandom});
            send_entry(mark);
         end else if (r < 88) begin
            for (int k = 0; k < ENTRY_SIZE; k++)
               entry_buf[k] = byte_type'($urandom_range(0, 255));
            send_entry(mark);
         end else begin
            // noise that breaks alignment
            n = $urandom_range(1, 40);
            for (int k = 0; k < n; k++)
               send_byte(byte_type'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end
      end
      req_ch.valid <= 1'b0;

      // drain
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_exfat_dir_entry_parser OK");
      end else begin
         $display("tb_exfat_dir_entry_parser NOT OK");
      end
      $finish;
   end

endmodule
